>>> rtl/config_descriptor_parser_assert.svh
// assertion macros shared by the descriptor parser modules
// depends on nothing; included inside module bodies
`ifndef CONFIG_DESCRIPTOR_PARSER_ASSERT_SVH
`define CONFIG_DESCRIPTOR_PARSER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CDP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cdp assertion failed");

// next-cycle implication, disabled during reset
`define CDP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cdp assertion failed");

`endif

>>> rtl/cdp_pkg.sv
// types and constants for the configuration descriptor parser
// depends on nothing
`timescale 1ns / 1ps

package cdp_pkg;

   localparam logic [7:0]  DESC_INTERFACE   = 8'd4;
   localparam logic [7:0]  DESC_ENDPOINT    = 8'd5;
   localparam logic [1:0]  XFER_INTERRUPT   = 2'b11;
   localparam int          DIR_IN_BIT       = 7;
   localparam logic [7:0]  RESET_INTERVAL   = 8'd10;

   localparam logic [7:0]  OFF_TYPE         = 8'd1;
   localparam logic [7:0]  OFF_EP_ADDRESS   = 8'd2;
   localparam logic [7:0]  OFF_EP_ATTR      = 8'd3;
   localparam logic [7:0]  OFF_EP_MAXPKT_LO = 8'd4;
   localparam logic [7:0]  OFF_EP_MAXPKT_HI = 8'd5;
   localparam logic [7:0]  OFF_EP_INTERVAL  = 8'd6;
   localparam logic [7:0]  OFF_IF_CLASS     = 8'd5;
   localparam logic [7:0]  OFF_IF_SUBCLASS  = 8'd6;
   localparam logic [7:0]  OFF_IF_PROTOCOL  = 8'd7;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } req_payload_type;

   typedef struct packed {
      logic        iface_found;
      logic [7:0]  intf_class;
      logic [7:0]  intf_subclass;
      logic [7:0]  intf_protocol;
      logic        ep_found;
      logic [7:0]  ep_address;
      logic [10:0] ep_max_packet;
      logic [7:0]  ep_interval;
   } rsp_payload_type;

   typedef struct packed {
      logic            accept;
      req_payload_type item;
   } step_type;

endpackage

>>> rtl/cdp_core.sv
// descriptor walker: offset tracking and capture registers, one byte per step
// depends on cdp_pkg and config_descriptor_parser_assert.svh
`timescale 1ns / 1ps

module cdp_core import cdp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  step_type        step,
   input  logic [7:0]      default_interval,
   output rsp_payload_type result
);

   logic [7:0]  offset_ff, offset_in;
   logic [7:0]  length_ff, length_in;
   logic [7:0]  dtype_ff, dtype_in;
   logic        stopped_ff, stopped_in;
   logic        have_iface_ff, have_iface_in;
   logic [7:0]  class_ff, class_in;
   logic [7:0]  subclass_ff, subclass_in;
   logic [7:0]  protocol_ff, protocol_in;
   logic        have_ep_ff, have_ep_in;
   logic [7:0]  tmp_addr_ff, tmp_addr_in;
   logic [7:0]  tmp_attr_ff, tmp_attr_in;
   logic [7:0]  tmp_lo_ff, tmp_lo_in;
   logic [10:0] tmp_pkt_ff, tmp_pkt_in;
   logic [7:0]  ep_addr_ff, ep_addr_in;
   logic [10:0] ep_pkt_ff, ep_pkt_in;
   logic [7:0]  ep_ival_ff, ep_ival_in;
   logic [8:0]  offset_inc;
   logic [7:0]  b;

   assign b = step.item.data_byte;

   always_comb begin
      offset_in     = offset_ff;
      length_in     = length_ff;
      dtype_in      = dtype_ff;
      stopped_in    = stopped_ff;
      have_iface_in = have_iface_ff;
      class_in      = class_ff;
      subclass_in   = subclass_ff;
      protocol_in   = protocol_ff;
      have_ep_in    = have_ep_ff;
      tmp_addr_in   = tmp_addr_ff;
      tmp_attr_in   = tmp_attr_ff;
      tmp_lo_in     = tmp_lo_ff;
      tmp_pkt_in    = tmp_pkt_ff;
      ep_addr_in    = ep_addr_ff;
      ep_pkt_in     = ep_pkt_ff;
      ep_ival_in    = ep_ival_ff;
      offset_inc    = {1'b0, offset_ff} + 9'd1;

      if (step.accept && !stopped_ff) begin
         if (offset_ff == 8'd0) begin
            if (b == 8'd0) begin
               stopped_in = 1'b1;
            end else begin
               length_in = b;
               dtype_in  = 8'd0;
            end
         end else if (offset_ff == OFF_TYPE) begin
            dtype_in = b;
         end else if (dtype_ff == DESC_INTERFACE && !have_iface_ff) begin
            if (offset_ff == OFF_IF_CLASS) begin
               class_in = b;
            end else if (offset_ff == OFF_IF_SUBCLASS) begin
               subclass_in = b;
            end else if (offset_ff == OFF_IF_PROTOCOL) begin
               protocol_in   = b;
               have_iface_in = 1'b1;
            end
         end else if (dtype_ff == DESC_ENDPOINT && have_iface_ff && !have_ep_ff) begin
            if (offset_ff == OFF_EP_ADDRESS) begin
               tmp_addr_in = b;
            end else if (offset_ff == OFF_EP_ATTR) begin
               tmp_attr_in = b;
            end else if (offset_ff == OFF_EP_MAXPKT_LO) begin
               tmp_lo_in = b;
            end else if (offset_ff == OFF_EP_MAXPKT_HI) begin
               tmp_pkt_in = {b[2:0], tmp_lo_ff};
            end else if (offset_ff == OFF_EP_INTERVAL) begin
               if (tmp_attr_ff[1:0] == XFER_INTERRUPT && tmp_addr_ff[DIR_IN_BIT]) begin
                  have_ep_in = 1'b1;
                  ep_addr_in = tmp_addr_ff;
                  ep_pkt_in  = tmp_pkt_ff;
                  ep_ival_in = (b != 8'd0) ? b : default_interval;
               end
            end
         end

         if (!stopped_in) begin
            if (offset_inc >= {1'b0, length_in}) begin
               offset_in = 8'd0;
            end else begin
               offset_in = offset_inc[7:0];
            end
         end
      end

      result.iface_found    = have_iface_in;
      result.intf_class     = have_iface_in ? class_in : 8'd0;
      result.intf_subclass  = have_iface_in ? subclass_in : 8'd0;
      result.intf_protocol  = have_iface_in ? protocol_in : 8'd0;
      result.ep_found       = have_ep_in;
      result.ep_address     = have_ep_in ? ep_addr_in : 8'd0;
      result.ep_max_packet  = have_ep_in ? ep_pkt_in : 11'd0;
      result.ep_interval    = have_ep_in ? ep_ival_in : 8'd0;

      // end of buffer: start the next one from scratch
      if (step.accept && step.item.last) begin
         offset_in     = 8'd0;
         length_in     = 8'd0;
         dtype_in      = 8'd0;
         stopped_in    = 1'b0;
         have_iface_in = 1'b0;
         class_in      = 8'd0;
         subclass_in   = 8'd0;
         protocol_in   = 8'd0;
         have_ep_in    = 1'b0;
         tmp_addr_in   = 8'd0;
         tmp_attr_in   = 8'd0;
         tmp_lo_in     = 8'd0;
         tmp_pkt_in    = 11'd0;
         ep_addr_in    = 8'd0;
         ep_pkt_in     = 11'd0;
         ep_ival_in    = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff     <= 8'd0;
         length_ff     <= 8'd0;
         dtype_ff      <= 8'd0;
         stopped_ff    <= 1'b0;
         have_iface_ff <= 1'b0;
         class_ff      <= 8'd0;
         subclass_ff   <= 8'd0;
         protocol_ff   <= 8'd0;
         have_ep_ff    <= 1'b0;
         tmp_addr_ff   <= 8'd0;
         tmp_attr_ff   <= 8'd0;
         tmp_lo_ff     <= 8'd0;
         tmp_pkt_ff    <= 11'd0;
         ep_addr_ff    <= 8'd0;
         ep_pkt_ff     <= 11'd0;
         ep_ival_ff    <= 8'd0;
      end else begin
         offset_ff     <= offset_in;
         length_ff     <= length_in;
         dtype_ff      <= dtype_in;
         stopped_ff    <= stopped_in;
         have_iface_ff <= have_iface_in;
         class_ff      <= class_in;
         subclass_ff   <= subclass_in;
         protocol_ff   <= protocol_in;
         have_ep_ff    <= have_ep_in;
         tmp_addr_ff   <= tmp_addr_in;
         tmp_attr_ff   <= tmp_attr_in;
         tmp_lo_ff     <= tmp_lo_in;
         tmp_pkt_ff    <= tmp_pkt_in;
         ep_addr_ff    <= ep_addr_in;
         ep_pkt_ff     <= ep_pkt_in;
         ep_ival_ff    <= ep_ival_in;
      end
   end

`include "config_descriptor_parser_assert.svh"

   `CDP_ASSERT_NOW(a_stopped_at_header, clock, reset, stopped_ff, offset_ff == 8'd0)
   `CDP_ASSERT_NOW(a_ep_needs_iface, clock, reset, have_ep_ff, have_iface_ff)
   `CDP_ASSERT_NOW(a_offset_in_desc, clock, reset, offset_ff != 8'd0, offset_ff < length_ff)

endmodule

>>> rtl/config_descriptor_parser.sv
// configuration descriptor parser: takes one byte per cycle, reports the first
// interface and its first interrupt IN endpoint at the byte marked last.
// Rate: one byte is accepted every cycle that req_ready is high; the result
// appears in the output register the cycle after the last byte. req_ready drops
// only while a result sits in the output register and rsp_ready is low.
// depends on cdp_pkg, cdp_core and config_descriptor_parser_assert.svh
`timescale 1ns / 1ps

module config_descriptor_parser import cdp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   input  logic            csr_write_enable,
   input  logic [7:0]      csr_write_data
);

   logic [7:0]      interval_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;
   rsp_payload_type result;
   step_type        step;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step      = {req_valid && req_ready, req_payload};

   cdp_core u_core (
      .clock            (clock),
      .reset            (reset),
      .step             (step),
      .default_interval (interval_ff),
      .result           (result)
   );

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      if (step.accept && step.item.last) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff  <= RESET_INTERVAL;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            interval_ff <= csr_write_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`include "config_descriptor_parser_assert.svh"

   `CDP_ASSERT_NEXT(a_last_gives_result, clock, reset, step.accept && step.item.last, rsp_valid)
   `CDP_ASSERT_NOW(a_stall_blocks_input, clock, reset, rsp_valid && !rsp_ready, !req_ready)
   `CDP_ASSERT_NEXT(a_csr_write, clock, reset, csr_write_enable,
                    interval_ff == $past(csr_write_data))

endmodule

>>> sim/testbench.sv
// testbench for config_descriptor_parser: byte-serial descriptor buffers in, one report per buffer
// depends on cdp_pkg and the config_descriptor_parser rtl; predicts reports and checks each field
`timescale 1ns / 1ps

module testbench;
   import cdp_pkg::*;

   localparam int CLOCK_PERIOD = 8;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASE_BYTES  = 100;
   localparam int PHASE_FRAMES = 8;
   localparam int LONG_HOLD    = 200;
   localparam logic [7:0] DESC_CONFIG = 8'd2;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_write_enable = 1'b0;
   logic [7:0]      csr_write_data = '0;

   config_descriptor_parser dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   req_payload_type byte_stream[$];
   rsp_payload_type expected_reports[$];
   logic [7:0]      frame[$];

   logic idle_on = 1'b1;
   int   hold_requests = 0;
   int   hold_served = 0;
   int   hold_left = 0;
   int   send_gap = 0;
   int   rsp_gap = 0;
   int   cycle_count = 0;
   int   mismatches = 0;
   int   reports_checked = 0;
   int   iface_hits = 0;
   int   ep_hits = 0;
   int   bytes_queued = 0;
   int   buffers_queued = 0;

   // predictor state
   logic [7:0]  poll_default = RESET_INTERVAL;
   logic [7:0]  walk_pos = '0;
   logic [7:0]  desc_len = '0;
   logic [7:0]  desc_kind = '0;
   logic        walk_halted = 1'b0;
   logic        iface_seen = 1'b0;
   logic [7:0]  if_class = '0;
   logic [7:0]  if_subclass = '0;
   logic [7:0]  if_protocol = '0;
   logic        ep_seen = 1'b0;
   logic [7:0]  ep_addr_tmp = '0;
   logic [7:0]  ep_attr_tmp = '0;
   logic [7:0]  ep_mp_low = '0;
   logic [10:0] ep_mp_tmp = '0;
   logic [7:0]  ep_addr = '0;
   logic [10:0] ep_mp = '0;
   logic [7:0]  ep_poll = '0;

   task automatic parse_descriptor_byte(input req_payload_type item);
      rsp_payload_type report;
      logic [7:0] b;
      b = item.data_byte;
      if (!walk_halted) begin
         if (walk_pos == 8'd0) begin
            if (b == 8'd0) begin
               walk_halted = 1'b1;
            end else begin
               desc_len = b;
               desc_kind = '0;
            end
         end else if (walk_pos == OFF_TYPE) begin
            desc_kind = b;
         end else if (desc_kind == DESC_INTERFACE && !iface_seen) begin
            case (walk_pos)
               OFF_IF_CLASS:    if_class = b;
               OFF_IF_SUBCLASS: if_subclass = b;
               OFF_IF_PROTOCOL: begin
                  if_protocol = b;
                  iface_seen = 1'b1;
               end
               default: ;
            endcase
         end else if (desc_kind == DESC_ENDPOINT && iface_seen && !ep_seen) begin
            case (walk_pos)
               OFF_EP_ADDRESS:   ep_addr_tmp = b;
               OFF_EP_ATTR:      ep_attr_tmp = b;
               OFF_EP_MAXPKT_LO: ep_mp_low = b;
               OFF_EP_MAXPKT_HI: ep_mp_tmp = {b[2:0], ep_mp_low};
               OFF_EP_INTERVAL: begin
                  if (ep_attr_tmp[1:0] == XFER_INTERRUPT && ep_addr_tmp[DIR_IN_BIT]) begin
                     ep_seen = 1'b1;
                     ep_addr = ep_addr_tmp;
                     ep_mp = ep_mp_tmp;
                     ep_poll = (b != 8'd0) ? b : poll_default;
                  end
               end
               default: ;
            endcase
         end
         if (!walk_halted) begin
            walk_pos = (int'(walk_pos) + 1 >= int'(desc_len)) ? 8'd0 : walk_pos + 8'd1;
         end
      end
      if (item.last) begin
         report.iface_found    = iface_seen;
         report.intf_class     = iface_seen ? if_class : 8'd0;
         report.intf_subclass  = iface_seen ? if_subclass : 8'd0;
         report.intf_protocol  = iface_seen ? if_protocol : 8'd0;
         report.ep_found       = ep_seen;
         report.ep_address     = ep_seen ? ep_addr : 8'd0;
         report.ep_max_packet  = ep_seen ? ep_mp : 11'd0;
         report.ep_interval    = ep_seen ? ep_poll : 8'd0;
         expected_reports.push_back(report);
         iface_hits += int'(iface_seen);
         ep_hits += int'(ep_seen);
         walk_pos = '0;
         desc_len = '0;
         desc_kind = '0;
         walk_halted = 1'b0;
         iface_seen = 1'b0;
         if_class = '0;
         if_subclass = '0;
         if_protocol = '0;
         ep_seen = 1'b0;
         ep_addr_tmp = '0;
         ep_attr_tmp = '0;
         ep_mp_low = '0;
         ep_mp_tmp = '0;
         ep_addr = '0;
         ep_mp = '0;
         ep_poll = '0;
      end
   endtask

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   // descriptor building
   function automatic int add_desc(int len, logic [7:0] kind);
      int base;
      base = frame.size();
      frame.push_back(8'(len));
      if (len > 1) frame.push_back(kind);
      for (int i = 2; i < len; i++) frame.push_back(8'($urandom));
      return base;
   endfunction

   function automatic void set_field(int base, int off, logic [7:0] value);
      if (base + off < frame.size()) frame[base + off] = value;
   endfunction

   task automatic flush_frame(int keep);
      req_payload_type item;
      if (keep > 0 && keep < frame.size()) frame = frame[0:keep - 1];
      foreach (frame[i]) begin
         item.data_byte = frame[i];
         item.last = (i == frame.size() - 1);
         byte_stream.push_back(item);
      end
      bytes_queued += frame.size();
      buffers_queued++;
      frame.delete();
   endtask

   task automatic gen_frame();
      int base;
      int len;
      int pick;
      int count;
      logic [7:0] addr;
      logic [7:0] attr;
      if ($urandom_range(0, 5) == 0) begin
         count = $urandom_range(1, 20);
         repeat (count) frame.push_back(8'($urandom));
      end else begin
         if ($urandom_range(0, 3) != 0) base = add_desc(9, DESC_CONFIG);
         count = $urandom_range(2, 6);
         repeat (count) begin
            pick = $urandom_range(0, 15);
            if (pick <= 4 || pick == 15) begin
               if (pick == 0) len = $urandom_range(2, 8);
               else if (pick == 15) len = $urandom_range(10, 20);
               else len = 9;
               base = add_desc(len, DESC_INTERFACE);
            end else if (pick <= 10) begin
               len = (pick == 5) ? $urandom_range(2, 6) : 7;
               base = add_desc(len, DESC_ENDPOINT);
               addr = 8'($urandom);
               attr = 8'($urandom);
               if ($urandom_range(0, 3) != 0) addr[DIR_IN_BIT] = 1'b1;
               if ($urandom_range(0, 3) != 0) attr[1:0] = XFER_INTERRUPT;
               set_field(base, OFF_EP_ADDRESS, addr);
               set_field(base, OFF_EP_ATTR, attr);
               if ($urandom_range(0, 3) == 0) set_field(base, OFF_EP_INTERVAL, 8'd0);
            end else if (pick <= 12) begin
               base = add_desc($urandom_range(2, 12), 8'($urandom));
            end else if (pick == 13) begin
               base = add_desc(1, 8'd0);
            end else begin
               frame.push_back(8'd0);
            end
         end
      end
      flush_frame(($urandom_range(0, 4) == 0) ? $urandom_range(1, frame.size()) : 0);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (byte_stream.size() != 0 || req_valid || expected_reports.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // byte driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (byte_stream.size() > 0) begin
            req_payload <= byte_stream.pop_front();
            req_valid <= 1'b1;
            if (idle_on && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 7);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // report receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served++;
         hold_left = LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (idle_on && $urandom_range(0, 5) == 0) rsp_gap = $urandom_range(1, 7);
      end
   end

   // monitor
   always @(posedge clock) begin : monitor
      rsp_payload_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end else if (!reset) begin
         if (req_valid && req_ready) parse_descriptor_byte(req_payload);
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               $error("report transaction with none expected");
               mismatches++;
            end else begin
               want = expected_reports.pop_front();
               check_field("iface_found", 16'(want.iface_found),
                           16'(rsp_payload.iface_found));
               check_field("intf_class", 16'(want.intf_class),
                           16'(rsp_payload.intf_class));
               check_field("intf_subclass", 16'(want.intf_subclass),
                           16'(rsp_payload.intf_subclass));
               check_field("intf_protocol", 16'(want.intf_protocol),
                           16'(rsp_payload.intf_protocol));
               check_field("ep_found", 16'(want.ep_found), 16'(rsp_payload.ep_found));
               check_field("ep_address", 16'(want.ep_address),
                           16'(rsp_payload.ep_address));
               check_field("ep_max_packet", 16'(want.ep_max_packet),
                           16'(rsp_payload.ep_max_packet));
               check_field("ep_interval", 16'(want.ep_interval),
                           16'(rsp_payload.ep_interval));
               reports_checked++;
            end
         end
      end
   end

   initial begin : stimulus
      int base;
      int start_bytes;
      int start_buffers;
      logic [7:0] setting;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // zero length as the only byte
      frame.push_back(8'd0);
      flush_frame(0);
      // length one skip, full interface, interrupt in endpoint with zero interval
      frame.push_back(8'd1);
      base = add_desc(9, DESC_INTERFACE);
      set_field(base, OFF_IF_CLASS, 8'hFF);
      set_field(base, OFF_IF_SUBCLASS, 8'h00);
      set_field(base, OFF_IF_PROTOCOL, 8'hFF);
      base = add_desc(7, DESC_ENDPOINT);
      set_field(base, OFF_EP_ADDRESS, 8'h81);
      set_field(base, OFF_EP_ATTR, 8'h03);
      set_field(base, OFF_EP_MAXPKT_LO, 8'hFF);
      set_field(base, OFF_EP_MAXPKT_HI, 8'hFF);
      set_field(base, OFF_EP_INTERVAL, 8'h00);
      flush_frame(0);
      // interface cut short by the end of the buffer
      base = add_desc(255, DESC_INTERFACE);
      flush_frame(6);

      for (int phase = 0; phase < 6; phase++) begin
         wait_idle();
         case (phase)
            0: setting = 8'd255;
            1: setting = 8'd1;
            default: setting = 8'($urandom_range(1, 255));
         endcase
         @(posedge clock);
         csr_write_enable <= 1'b1;
         csr_write_data <= setting;
         @(posedge clock);
         csr_write_enable <= 1'b0;
         poll_default = setting;
         @(negedge clock);
         if (phase == 2) hold_requests <= hold_requests + 1;
         if (phase == 5) idle_on <= 1'b0;
         start_bytes = bytes_queued;
         start_buffers = buffers_queued;
         while (bytes_queued - start_bytes < PHASE_BYTES ||
                buffers_queued - start_buffers < PHASE_FRAMES) begin
            gen_frame();
         end
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (expected_reports.size() != 0) begin
         $error("%0d reports never arrived", expected_reports.size());
         mismatches++;
      end
      $display("checked %0d reports from %0d bytes in %0d buffers",
               reports_checked, bytes_queued, buffers_queued);
      $display("reports with an interface: %0d, with an interrupt in endpoint: %0d",
               iface_hits, ep_hits);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/cdp_pkg.sv
rtl/cdp_core.sv
rtl/config_descriptor_parser.sv
sim/testbench.sv
